/* rtl/core/qar_pkg.sv */
// Shared constants, types and term tables of the quaternion accumulate and renormalize core.
package qar_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = COMP_WIDTH - 2;
  localparam int ACC_W      = 2 * COMP_WIDTH + 2;
  localparam int RND_W      = ACC_W - FRAC_BITS;
  localparam int SQ_W       = 2 * COMP_WIDTH + 1;
  localparam int NORM_W     = COMP_WIDTH + 1;
  localparam int NUM_W      = COMP_WIDTH + FRAC_BITS;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int PERIOD_W   = 8;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [COMP_WIDTH-1:0]        mag_t;
  typedef logic [PERIOD_W-1:0]          period_t;
  typedef logic [1:0]                   cidx_t;

  localparam period_t PERIOD_RESET = period_t'(97);
  localparam logic    REG_PERIOD   = 1'b0;

  localparam cidx_t CX = 2'd0;
  localparam cidx_t CY = 2'd1;
  localparam cidx_t CZ = 2'd2;
  localparam cidx_t CW = 2'd3;

  // For each result component, the four product terms: spin operand, stored operand, negated.
  localparam cidx_t SPIN_SEL [4][4] = '{
    '{CX, CW, CZ, CY},
    '{CY, CW, CX, CZ},
    '{CZ, CW, CY, CX},
    '{CW, CX, CY, CZ}
  };
  localparam cidx_t ORI_SEL [4][4] = '{
    '{CW, CX, CY, CZ},
    '{CW, CY, CZ, CX},
    '{CW, CZ, CX, CY},
    '{CW, CX, CY, CZ}
  };
  localparam logic [3:0] NEG_SEL [4] = '{4'b1000, 4'b1000, 4'b1000, 4'b1110};

endpackage

/* rtl/core/qar_if.sv */
// Handshake interfaces for the input and result words of the quaternion core.
interface qar_in_if;
  import qar_pkg::*;
  logic  valid;
  logic  ready;
  comp_t spin_x;
  comp_t spin_y;
  comp_t spin_z;
  comp_t spin_w;
  modport source (output valid, spin_x, spin_y, spin_z, spin_w, input ready);
  modport sink (input valid, spin_x, spin_y, spin_z, spin_w, output ready);
endinterface

interface qar_out_if;
  import qar_pkg::*;
  logic  valid;
  logic  ready;
  comp_t new_x;
  comp_t new_y;
  comp_t new_z;
  comp_t new_w;
  logic  renormalized;
  logic  saturated;
  modport source (output valid, new_x, new_y, new_z, new_w, renormalized, saturated,
                  input ready);
  modport sink (input valid, new_x, new_y, new_z, new_w, renormalized, saturated,
                output ready);
endinterface

/* rtl/core/quaternion_accumulate_renorm_core.sv */
// Quaternion orientation accumulator with periodic renormalization, bit-serial datapath.
//
//   channel  | direction | handshake          | contents
//   in_word  | in        | valid/ready        | spin_x, spin_y, spin_z, spin_w
//   out_word | out       | valid/ready        | new_x..new_w, renormalized, saturated
//   cfg_*    | in        | APB write, pready=1| renorm_period at byte address 0
//
// A word without renormalization is multiplied one multiplier bit per cycle, then rounded.
// A renormalizing word then goes on through the sum of squares, the square root, the
// divide load and the divide, and the quotients are written back before the result.
// One word is worked on at a time; the next is taken while a result waits in the output
// register. Reset restores the identity orientation, a zero count and a period of 97.
module quaternion_accumulate_renorm_core (
  input  logic                           clk,
  input  logic                           rst_n,
  qar_in_if.sink                         in_word,
  qar_out_if.source                      out_word,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [qar_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [qar_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [qar_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import qar_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DLD  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  localparam comp_t C_MAX = comp_t'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
  localparam comp_t C_MIN = ~C_MAX;
  localparam logic signed [RND_W-1:0] R_MAX = RND_W'(C_MAX);
  localparam logic signed [RND_W-1:0] R_MIN = RND_W'(C_MIN);
  localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(mag_t'(C_MAX));
  localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(mag_t'(C_MIN));

  logic [2:0]                state_r;
  logic [CNT_W-1:0]          cnt_r;
  period_t                   period_r;
  logic [PERIOD_W-1:0]       count_r;
  comp_t                     ori_r [4];
  comp_t                     spin_r [4];
  logic signed [ACC_W-1:0]   acc_r [4];
  logic signed [ACC_W-1:0]   acc_nxt [4];
  mag_t                      mag_r [4];
  mag_t                      sqsh_r [4];
  logic [SQ_W-1:0]           n_r;
  logic [SQ_W-1:0]           n_nxt;
  logic [SQ_W-1:0]           res_r;
  logic [SQ_W-1:0]           bit_r;
  logic [NORM_W-1:0]         norm_r;
  logic [NUM_W-1:0]          qd_r [4];
  logic [NORM_W-1:0]         rem_r [4];
  logic                      sat_r;
  logic                      ren_r;
  logic                      out_valid_r;
  comp_t                     rnd_c [4];
  logic                      rnd_sat;
  logic                      last_bit;
  logic [PERIOD_W:0]         count_inc;
  logic [SQ_W:0]             root_trial;
  logic                      in_acc;
  logic                      out_free;
  logic                      out_load;

  assign cfg_pready     = 1'b1;
  assign cfg_prdata     = DATA_W'(period_r);
  assign in_word.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_word.valid && in_word.ready;
  assign out_word.valid = out_valid_r;
  assign out_free       = !out_valid_r || out_word.ready;
  assign out_load       = (state_r == ST_DONE) && !(ren_r && cnt_r == CNT_W'(NUM_W)) &&
                          out_free;
  assign last_bit       = (cnt_r == CNT_W'(COMP_WIDTH - 1));
  assign count_inc      = {1'b0, count_r} + 1'b1;
  assign root_trial     = {1'b0, res_r} + {1'b0, bit_r};

  always_comb begin
    logic signed [ACC_W-1:0] term;
    for (int l = 0; l < 4; l++) begin
      acc_nxt[l] = acc_r[l];
      for (int k = 0; k < 4; k++) begin
        term = ACC_W'(ori_r[ORI_SEL[l][k]]) <<< cnt_r;
        if (spin_r[SPIN_SEL[l][k]][0]) begin
          if (NEG_SEL[l][k] ^ last_bit) begin
            acc_nxt[l] = acc_nxt[l] - term;
          end else begin
            acc_nxt[l] = acc_nxt[l] + term;
          end
        end
      end
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] rsum;
    logic signed [RND_W-1:0] rv;
    rnd_sat = 1'b0;
    for (int l = 0; l < 4; l++) begin
      rsum = acc_r[l] + (ACC_W'(1) <<< (FRAC_BITS - 1));
      rv   = $signed(rsum[ACC_W-1:FRAC_BITS]);
      if (rv > R_MAX) begin
        rnd_c[l] = C_MAX;
        rnd_sat  = 1'b1;
      end else if (rv < R_MIN) begin
        rnd_c[l] = C_MIN;
        rnd_sat  = 1'b1;
      end else begin
        rnd_c[l] = rv[COMP_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    n_nxt = n_r;
    for (int c = 0; c < 4; c++) begin
      if (sqsh_r[c][0]) begin
        n_nxt = n_nxt + (SQ_W'(mag_r[c]) << cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      period_r    <= PERIOD_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ori_r[CX]   <= '0;
      ori_r[CY]   <= '0;
      ori_r[CZ]   <= '0;
      ori_r[CW]   <= comp_t'(64'd1 << FRAC_BITS);
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_PERIOD) begin
        period_r <= cfg_pwdata[PERIOD_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            spin_r[CX] <= in_word.spin_x;
            spin_r[CY] <= in_word.spin_y;
            spin_r[CZ] <= in_word.spin_z;
            spin_r[CW] <= in_word.spin_w;
            for (int l = 0; l < 4; l++) acc_r[l] <= '0;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          for (int l = 0; l < 4; l++) begin
            acc_r[l]  <= acc_nxt[l];
            spin_r[l] <= spin_r[l] >>> 1;
          end
          cnt_r <= cnt_r + 1'b1;
          if (last_bit) begin
            state_r <= ST_RND;
          end
        end
        ST_RND: begin
          for (int c = 0; c < 4; c++) begin
            ori_r[c]  <= rnd_c[c];
            mag_r[c]  <= rnd_c[c][COMP_WIDTH-1] ? mag_t'(-rnd_c[c]) : mag_t'(rnd_c[c]);
            sqsh_r[c] <= rnd_c[c][COMP_WIDTH-1] ? mag_t'(-rnd_c[c]) : mag_t'(rnd_c[c]);
          end
          sat_r <= rnd_sat;
          ren_r <= 1'b0;
          n_r   <= '0;
          cnt_r <= '0;
          if (count_inc > {1'b0, period_r}) begin
            count_r <= '0;
            state_r <= ST_SQ;
          end else begin
            count_r <= count_inc[PERIOD_W-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_SQ: begin
          n_r   <= n_nxt;
          cnt_r <= cnt_r + 1'b1;
          for (int c = 0; c < 4; c++) sqsh_r[c] <= sqsh_r[c] >> 1;
          if (last_bit) begin
            res_r   <= '0;
            bit_r   <= SQ_W'(1) << (SQ_W - 1);
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if ({1'b0, n_r} >= root_trial) begin
            n_r   <= n_r - root_trial[SQ_W-1:0];
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= ST_DLD;
          end
        end
        ST_DLD: begin
          norm_r <= res_r[NORM_W-1:0];
          cnt_r  <= '0;
          for (int c = 0; c < 4; c++) begin
            qd_r[c]  <= (NUM_W'(mag_r[c]) << FRAC_BITS) + NUM_W'(res_r[NORM_W-1:1]);
            rem_r[c] <= '0;
          end
          state_r <= (res_r == '0) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          for (int c = 0; c < 4; c++) begin
            if ({rem_r[c], qd_r[c][NUM_W-1]} >= {1'b0, norm_r}) begin
              rem_r[c] <= NORM_W'({rem_r[c], qd_r[c][NUM_W-1]} - {1'b0, norm_r});
              qd_r[c]  <= {qd_r[c][NUM_W-2:0], 1'b1};
            end else begin
              rem_r[c] <= NORM_W'({rem_r[c], qd_r[c][NUM_W-1]});
              qd_r[c]  <= {qd_r[c][NUM_W-2:0], 1'b0};
            end
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(NUM_W - 1)) begin
            for (int c = 0; c < 4; c++) ori_r[c] <= ori_r[c];
            state_r <= ST_DONE;
            ren_r   <= 1'b1;
          end
        end
        ST_DONE: begin
          if (ren_r && cnt_r == CNT_W'(NUM_W)) begin
            for (int c = 0; c < 4; c++) begin
              if (ori_r[c][COMP_WIDTH-1]) begin
                ori_r[c] <= (qd_r[c] > Q_NEG_MAX) ? C_MIN : -comp_t'(qd_r[c][COMP_WIDTH-1:0]);
              end else begin
                ori_r[c] <= (qd_r[c] > Q_POS_MAX) ? C_MAX : comp_t'(qd_r[c][COMP_WIDTH-1:0]);
              end
            end
            cnt_r <= '0;
          end else if (out_free) begin
            out_word.new_x        <= ori_r[CX];
            out_word.new_y        <= ori_r[CY];
            out_word.new_z        <= ori_r[CZ];
            out_word.new_w        <= ori_r[CW];
            out_word.renormalized <= ren_r;
            out_word.saturated    <= sat_r;
            state_r               <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_MUL)
    else $error("accepted word did not start the multiply");

  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> $onehot(bit_r))
    else $error("square root bit lost");

  a_div_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> norm_r != '0)
    else $error("divide started with a zero norm");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word raised outside the done state");

endmodule
